// ===== rtl/core/bsfi_pkg.sv =====
package bsfi_pkg;

    localparam int CFG_ADDR_BITS   = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int FRONT_SIZE_BITS = 5;
    localparam int IN_KEY_BITS     = 32;
    localparam int ID_BITS         = 32;
    localparam int POS_BITS        = 4;
    localparam int COUNT_BITS      = 5;

    localparam logic [0:0]                 REG_FRONT_SIZE   = 1'b0;
    localparam logic [FRONT_SIZE_BITS-1:0] FRONT_SIZE_RESET = 5'd16;

    typedef struct packed {
        logic accept;
        logic occupied;
        logic append_here;
    } cell_ctrl_t;

    typedef struct packed {
        logic ge;
        logic first;
    } cell_stat_t;

endpackage

// ===== rtl/core/bsfi_cell.sv =====
module bsfi_cell
    import bsfi_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [ID_BITS-1:0]  new_id,
    input  logic                left_ge,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [ID_BITS-1:0]  left_id,
    output cell_stat_t          stat,
    output logic [KEY_BITS-1:0] key,
    output logic [ID_BITS-1:0]  id
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [ID_BITS-1:0]  id_reg;
    logic [ID_BITS-1:0]  id_next;

    always_comb
    begin
        stat.ge    = ctrl.occupied && (new_key <= key_reg);
        stat.first = stat.ge && !left_ge;
    end

    always_comb
    begin
        key_next = key_reg;
        id_next  = id_reg;
        if (ctrl.accept)
        begin
            if (stat.first || ctrl.append_here)
            begin
                key_next = new_key;
                id_next  = new_id;
            end
            else if (left_ge)
            begin
                key_next = left_key;
                id_next  = left_id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign key = key_reg;
    assign id  = id_reg;

endmodule

// ===== rtl/core/bounded_sorted_front_insert_top.sv =====
// channel   direction  handshake                   payload
// entry     in         entry_valid / entry_stall   entry_key, entry_id
// result    out        result_valid / result_stall was_added, insert_position, evict_valid,
//                                                  evicted_id, entry_count
// config    in         apb write, pready tied high front_size at word 0
//
// one request per cycle while entry_stall is low; its result is registered and shows in
// the cycle after acceptance, from the compare in every cell of the row and the position
// and evicted-id or-trees, all settled in the accepting cycle
// reset empties the row (fill count zero) and sets front_size to 16; cell contents stay
// a held result stalls entry only while result_stall is high

module bounded_sorted_front_insert_top
    import bsfi_pkg::*;
#(
    parameter int MAX_DEPTH = 16,
    parameter int KEY_BITS  = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     entry_valid,
    output logic                     entry_stall,
    input  logic [IN_KEY_BITS-1:0]   entry_key,
    input  logic [ID_BITS-1:0]       entry_id,

    output logic                     result_valid,
    input  logic                     result_stall,
    output logic                     was_added,
    output logic [POS_BITS-1:0]      insert_position,
    output logic                     evict_valid,
    output logic [ID_BITS-1:0]       evicted_id,
    output logic [COUNT_BITS-1:0]    entry_count,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int LW = (CW > FRONT_SIZE_BITS) ? CW : FRONT_SIZE_BITS;
    localparam int SW = LW + 1;

    logic [FRONT_SIZE_BITS-1:0] front_size_reg;
    logic [FRONT_SIZE_BITS-1:0] front_size_next;
    logic [CW-1:0]              fill_count_reg;
    logic [CW-1:0]              fill_count_next;

    logic                       result_valid_reg;
    logic                       result_valid_next;
    logic                       was_added_reg;
    logic [POS_BITS-1:0]        insert_position_reg;
    logic                       evict_valid_reg;
    logic [ID_BITS-1:0]         evicted_id_reg;
    logic [COUNT_BITS-1:0]      entry_count_reg;

    logic                       accept;
    logic                       cfg_write;
    logic [KEY_BITS-1:0]        new_key;

    logic [SW-1:0]              n_ext;
    logic [SW-1:0]              limit_ext;
    logic [SW-1:0]              sum_ext;
    logic [SW-1:0]              n_new;
    logic                       found;
    logic                       append;
    logic                       added;
    logic                       evict;
    logic [POS_BITS-1:0]        pos_found;
    logic [POS_BITS-1:0]        position;
    logic [ID_BITS-1:0]         last_id;

    logic [MAX_DEPTH-1:0]       ge_vec;
    logic [MAX_DEPTH-1:0]       first_vec;
    cell_ctrl_t                 cell_ctrl [MAX_DEPTH];
    cell_stat_t                 cell_stat [MAX_DEPTH];
    logic [KEY_BITS-1:0]        cell_key  [MAX_DEPTH];
    logic [ID_BITS-1:0]         cell_id   [MAX_DEPTH];

    assign pready      = 1'b1;
    assign entry_stall = result_valid_reg && result_stall;
    assign accept      = entry_valid && !entry_stall;
    assign new_key     = KEY_BITS'(entry_key);

    // config port
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[CFG_ADDR_BITS-1:2] == REG_FRONT_SIZE);

    always_comb
    begin
        front_size_next = front_size_reg;
        if (cfg_write)
        begin
            front_size_next = pwdata[FRONT_SIZE_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[CFG_ADDR_BITS-1:2] == REG_FRONT_SIZE)
        begin
            prdata = CFG_DATA_BITS'(front_size_reg);
        end
    end

    // row of cells
    genvar g;
    generate
        for (g = 0; g < MAX_DEPTH; g++)
        begin : g_cell
            assign cell_ctrl[g].accept      = accept;
            assign cell_ctrl[g].occupied    = SW'(g) < n_ext;
            assign cell_ctrl[g].append_here = append && (SW'(g) == n_ext);
            assign ge_vec[g]                = cell_stat[g].ge;
            assign first_vec[g]             = cell_stat[g].first;

            if (g == 0)
            begin : g_head
                bsfi_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .clk      (clk),
                    .ctrl     (cell_ctrl[g]),
                    .new_key  (new_key),
                    .new_id   (entry_id),
                    .left_ge  (1'b0),
                    .left_key (new_key),
                    .left_id  (entry_id),
                    .stat     (cell_stat[g]),
                    .key      (cell_key[g]),
                    .id       (cell_id[g])
                );
            end
            else
            begin : g_body
                bsfi_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .clk      (clk),
                    .ctrl     (cell_ctrl[g]),
                    .new_key  (new_key),
                    .new_id   (entry_id),
                    .left_ge  (cell_stat[g-1].ge),
                    .left_key (cell_key[g-1]),
                    .left_id  (cell_id[g-1]),
                    .stat     (cell_stat[g]),
                    .key      (cell_key[g]),
                    .id       (cell_id[g])
                );
            end
        end
    endgenerate

    // insert decision
    always_comb
    begin
        n_ext     = SW'(fill_count_reg);
        limit_ext = (SW'(front_size_reg) > SW'(MAX_DEPTH)) ? SW'(MAX_DEPTH)
                                                           : SW'(front_size_reg);
        found     = |ge_vec;
        append    = !found && (n_ext < limit_ext);
        added     = found || append;
        sum_ext   = n_ext + SW'(added);
        evict     = sum_ext > limit_ext;
        n_new     = sum_ext - SW'(evict);
    end

    always_comb
    begin
        pos_found = '0;
        last_id   = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if (first_vec[i])
            begin
                pos_found = pos_found | POS_BITS'(i);
            end
            if ((SW'(i) + SW'(1)) == n_ext)
            begin
                last_id = last_id | cell_id[i];
            end
        end
        position = '0;
        if (added)
        begin
            position = found ? pos_found : POS_BITS'(n_ext);
        end
    end

    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (accept)
        begin
            fill_count_next = CW'(n_new);
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (accept)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_size_reg   <= FRONT_SIZE_RESET;
            fill_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            front_size_reg   <= front_size_next;
            fill_count_reg   <= fill_count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            was_added_reg       <= added;
            insert_position_reg <= position;
            evict_valid_reg     <= evict;
            evicted_id_reg      <= evict ? last_id : '0;
            entry_count_reg     <= COUNT_BITS'(n_new);
        end
    end

    assign result_valid    = result_valid_reg;
    assign was_added       = was_added_reg;
    assign insert_position = insert_position_reg;
    assign evict_valid     = evict_valid_reg;
    assign evicted_id      = evicted_id_reg;
    assign entry_count     = entry_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(MAX_DEPTH))
        else $error("fill count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_vec))
        else $error("more than one insertion cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted request produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (SW'(fill_count_reg) == $past(n_ext) + SW'(1))
                   || (SW'(fill_count_reg) == $past(n_ext))
                   || (SW'(fill_count_reg) + SW'(1) == $past(n_ext)))
        else $error("fill count moved by more than one");

endmodule

// ===== test/tb.sv =====
module tb;
    import bsfi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PERCENT   = 11;

    typedef struct packed {
        logic                  added;
        logic [POS_BITS-1:0]   position;
        logic                  evicted;
        logic [ID_BITS-1:0]    evicted_id;
        logic [COUNT_BITS-1:0] count;
    } outcome_t;

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       entry_valid     = 1'b0;
    logic                       entry_stall;
    logic [IN_KEY_BITS-1:0]     entry_key       = '0;
    logic [ID_BITS-1:0]         entry_id        = '0;
    logic                       result_valid;
    logic                       result_stall    = 1'b0;
    logic                       was_added;
    logic [POS_BITS-1:0]        insert_position;
    logic                       evict_valid;
    logic [ID_BITS-1:0]         evicted_id;
    logic [COUNT_BITS-1:0]      entry_count;
    logic                       psel            = 1'b0;
    logic                       penable         = 1'b0;
    logic                       pwrite          = 1'b0;
    logic [CFG_ADDR_BITS-1:0]   paddr           = '0;
    logic [CFG_DATA_BITS-1:0]   pwdata          = '0;
    logic [CFG_DATA_BITS-1:0]   prdata;
    logic                       pready;

    // sorted front as the block should hold it
    logic [IN_KEY_BITS-1:0]     front_keys [0:DEPTH];
    logic [ID_BITS-1:0]         front_ids  [0:DEPTH];
    int unsigned                front_fill = 0;
    logic [FRONT_SIZE_BITS-1:0] size_limit = FRONT_SIZE_RESET;

    outcome_t                   pending_results [$];
    int                         fail_count   = 0;
    int                         quiet_cycles = 0;
    bit                         calm         = 1'b0;

    bounded_sorted_front_insert_top #(
        .MAX_DEPTH (DEPTH),
        .KEY_BITS  (IN_KEY_BITS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .entry_valid     (entry_valid),
        .entry_stall     (entry_stall),
        .entry_key       (entry_key),
        .entry_id        (entry_id),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .was_added       (was_added),
        .insert_position (insert_position),
        .evict_valid     (evict_valid),
        .evicted_id      (evicted_id),
        .entry_count     (entry_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic outcome_t insert_entry(logic [IN_KEY_BITS-1:0] key,
                                              logic [ID_BITS-1:0] id);
        outcome_t    res;
        int unsigned lim;
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        bit          found;
        res   = '0;
        lim   = (size_limit > DEPTH) ? DEPTH : size_limit;
        n     = front_fill;
        pos   = 0;
        found = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (!found && key <= front_keys[i])
            begin
                pos   = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            for (i = n; i > pos; i--)
            begin
                front_keys[i] = front_keys[i-1];
                front_ids[i]  = front_ids[i-1];
            end
        end
        else if (n < lim)
        begin
            pos = n;
        end
        if (found || n < lim)
        begin
            front_keys[pos] = key;
            front_ids[pos]  = id;
            n++;
            res.added    = 1'b1;
            res.position = pos[POS_BITS-1:0];
        end
        if (n > lim)
        begin
            n--;
            res.evicted    = 1'b1;
            res.evicted_id = front_ids[n];
        end
        front_fill = n;
        res.count  = n[COUNT_BITS-1:0];
        return res;
    endfunction

    function automatic void queue_result(outcome_t res);
        pending_results = {pending_results, res};
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // result side: check accepted results, then pick the next stall
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual id %0h", $time,
                         evicted_id);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("was_added", want.added, was_added);
                check_field("insert_position", want.position, insert_position);
                check_field("evict_valid", want.evicted, evict_valid);
                check_field("evicted_id", want.evicted_id, evicted_id);
                check_field("entry_count", want.count, entry_count);
            end
        end
        result_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (entry_valid && !entry_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_entry(input logic [IN_KEY_BITS-1:0] key, input logic [ID_BITS-1:0] id);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            entry_valid <= 1'b0;
            @(posedge clk);
        end
        entry_valid <= 1'b1;
        entry_key   <= key;
        entry_id    <= id;
        @(posedge clk);
        while (entry_stall)
            @(posedge clk);
        queue_result(insert_entry(key, id));
    endtask

    task automatic drain_results();
        entry_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic read_front_size();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_BITS'({REG_FRONT_SIZE, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("front_size readback", {27'd0, size_limit}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_front_size(input logic [FRONT_SIZE_BITS-1:0] size);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'({REG_FRONT_SIZE, 2'b00});
        pwdata  <= {27'($urandom_range(32'h07FF_FFFF, 0)), size};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        size_limit = size;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        read_front_size();
    endtask

    function automatic logic [IN_KEY_BITS-1:0] pick_key();
        case ($urandom_range(3))
            0: return IN_KEY_BITS'($urandom_range(15));
            1: return 32'hFFFF_FFF0 | IN_KEY_BITS'($urandom_range(15));
            2: return {16'($urandom_range(3)), 16'($urandom)};
            default: return IN_KEY_BITS'($urandom);
        endcase
    endfunction

    task automatic test_reset_value();
        read_front_size();
    endtask

    // root first, then ties land ahead of equal keys
    task automatic test_order_and_ties();
        send_entry(32'h0064_0000, 32'h0000_0001);
        send_entry(32'h0032_0000, 32'h0000_0002);
        send_entry(32'h0064_0000, 32'h0000_0003);
        send_entry(32'h0000_0000, 32'hFFFF_FFFF);
        send_entry(32'hFFFF_FFFF, 32'h0000_0005);
        send_entry(32'hFFFF_FFFF, 32'h8000_0006);
    endtask

    // size zero on a held list: one drop per request
    task automatic test_size_zero();
        write_front_size(5'd0);
        send_entry(32'h0001_0000, 32'h0000_0010);
        send_entry(32'hFFFF_FFFF, 32'h0000_0011);
        send_entry(32'h0000_0000, 32'h0000_0012);
    endtask

    // single slot: shrink, reject a larger key, replace with a smaller one
    task automatic test_size_one();
        write_front_size(5'd1);
        send_entry(32'h7FFF_FFFF, 32'h0000_0020);
        send_entry(32'hFFFF_FFFF, 32'h0000_0021);
        send_entry(32'h0000_0000, 32'h5555_AAAA);
    endtask

    task automatic test_full_front();
        int i;
        write_front_size(5'd16);
        for (i = 0; i < 16; i++)
            send_entry(32'h1000_0000 - i, 32'h0000_0100 + i);
        send_entry(32'hFFFF_FFFF, 32'hAAAA_5555);
    endtask

    task automatic test_random_phase(input logic [FRONT_SIZE_BITS-1:0] size,
                                     input int count, input bit no_idle);
        int i;
        write_front_size(size);
        calm = no_idle;
        for (i = 0; i < count; i++)
            send_entry(pick_key(), $urandom);
        drain_results();
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_value();
        test_order_and_ties();
        test_size_zero();
        test_size_one();
        test_full_front();
        test_random_phase(5'd31, 200, 1'b0);
        test_random_phase(5'd1, 120, 1'b0);
        test_random_phase(5'd16, 200, 1'b0);
        test_random_phase(5'd17, 150, 1'b0);
        test_random_phase(5'd3, 120, 1'b0);
        test_random_phase(5'd0, 50, 1'b0);
        test_random_phase(5'd8, 150, 1'b0);
        test_random_phase(5'd16, 200, 1'b1);
        test_random_phase(5'd2, 120, 1'b0);
        test_random_phase(5'd12, 150, 1'b0);
        test_random_phase(5'd5, 120, 1'b0);
        test_random_phase(5'd16, 250, 1'b0);
        drain_results();
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bsfi_pkg.sv
rtl/core/bsfi_cell.sv
rtl/core/bounded_sorted_front_insert_top.sv
test/tb.sv
